// ===== src/gosm_pkg.sv =====
// gosm_pkg: shared types and constants for the output slot mapper
// no dependencies; imported by the channel interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package gosm_pkg;

   // field widths
   localparam int NUMBER_W = 8;
   localparam int CODE_W   = 8;
   localparam int SLOT_W   = 4;
   localparam int MASK_W   = 16;

   // pin numbering: tens digit is the group, units digit is the pin
   localparam int DIGIT_BASE = 10;
   localparam int GROUP_MAX  = 9;
   localparam int PIN_MAX    = 7;

   // divide by ten through a reciprocal, exact for every 8-bit number
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int PROD_W      = 16;
   localparam int GROUP_W     = PROD_W - DIV10_SHIFT;

   // slot table entry that holds no pin
   localparam logic [CODE_W-1:0] UNUSED_CODE = 8'hff;

   typedef enum logic [1:0] {
      STATUS_REUSED  = 2'd0,
      STATUS_NEW     = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   // request broadcast along the cell chain
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              level;
      logic              push_pull;
   } slot_req_type;

   // what a cell reports back while it holds the probe
   typedef struct packed {
      logic hit;
      logic claim;
   } cell_stat_type;

endpackage

`default_nettype wire

// ===== src/gosm_req_if.sv =====
// gosm_req_if: request channel of the output slot mapper (valid/ready)
// depends on gosm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gosm_req_if import gosm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] gpio_number;
   logic                level;
   logic                push_pull;

   modport source (output valid, gpio_number, level, push_pull, input ready);
   modport sink   (input valid, gpio_number, level, push_pull, output ready);
endinterface

`default_nettype wire

// ===== src/gosm_rsp_if.sv =====
// gosm_rsp_if: result channel of the output slot mapper (valid/ready)
// depends on gosm_pkg for field widths and the status type
`timescale 1ns / 1ps
`default_nettype none

interface gosm_rsp_if import gosm_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [SLOT_W-1:0] slot;
   logic [MASK_W-1:0] type_mask;
   logic [MASK_W-1:0] level_mask;

   modport source (output valid, status, slot, type_mask, level_mask, input ready);
   modport sink   (input valid, status, slot, type_mask, level_mask, output ready);
endinterface

`default_nettype wire

// ===== src/gosm_cell.sv =====
// gosm_cell: one slot of the mapper chain, holding its code, drive and level bits
// depends on gosm_pkg; instantiated once per slot by gpio_output_slot_mapper_core
`timescale 1ns / 1ps
`default_nettype none

module gosm_cell import gosm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         probe_in,
   input  wire slot_req_type req,
   output logic              probe_out,
   output cell_stat_type     stat,
   output logic              drive_bit,
   output logic              level_bit
);

   logic [CODE_W-1:0] code_ff, code_in;
   logic              drive_ff, drive_in;
   logic              level_ff, level_in;
   logic              probe_ff;
   logic              unused;
   logic              hit;

   // first free or matching slot stops the probe here
   always_comb begin
      unused    = (code_ff == UNUSED_CODE);
      hit       = probe_ff & (unused | (code_ff == req.code));
      stat.hit  = hit;
      stat.claim = probe_ff & unused;
      probe_out = probe_ff & ~hit;
      code_in   = (probe_ff & unused) ? req.code : code_ff;
      drive_in  = hit ? req.push_pull : drive_ff;
      level_in  = hit ? req.level : level_ff;
   end

   // slot state and probe token
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= UNUSED_CODE;
         drive_ff <= 1'b0;
         level_ff <= 1'b0;
         probe_ff <= 1'b0;
      end else begin
         code_ff  <= code_in;
         drive_ff <= drive_in;
         level_ff <= level_in;
         probe_ff <= probe_in;
      end
   end

   assign drive_bit = drive_ff;
   assign level_bit = level_ff;

endmodule

`default_nettype wire

// ===== src/gpio_output_slot_mapper_core.sv =====
// gpio_output_slot_mapper_core: top level, request decode, probe chain and result register
// depends on gosm_pkg, gosm_req_if, gosm_rsp_if and gosm_cell
//
// Usage
//   req_ch carries a decimal pin number (group in the tens digit, pin in the units
//   digit), the level and the drive type. req_ch.ready is high while no request is
//   in work. rsp_ch returns one result per request: status, slot, and the push-pull
//   and level masks after the request.
// Sequence
//   A probe token walks the chain of slot cells, one cell a cycle. A request
//   that stops at a slot, or runs off the end of a full table, goes from the
//   scan state to the emit state, which moves its result into the output
//   register; only then is the next request taken. A rejected pin number skips
//   the scan and goes straight to the emit state.
// Reset
//   All slots read as unused and both masks are zero; no request is in work.
// Stalls
//   The result sits in an output register while rsp_ch.ready is low. The next
//   request is accepted meanwhile and its scan runs; it waits at the end of the
//   scan until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module gpio_output_slot_mapper_core import gosm_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   gosm_req_if.sink   req_ch,
   gosm_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   slot_req_type      req_ff, req_in;
   status_type        status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [MASK_W-1:0] rsp_type_ff, rsp_type_in;
   logic [MASK_W-1:0] rsp_level_ff, rsp_level_in;

   logic                  accept;
   logic                  start;
   logic                  bad_pin;
   logic [PROD_W-1:0]     quot_prod;
   logic [GROUP_W-1:0]    group;
   logic [NUMBER_W-1:0]   tens;
   logic [NUMBER_W-1:0]   pin;

   logic [SLOT_COUNT:0]   probe;
   cell_stat_type         stat [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] hit_vec;
   logic [SLOT_COUNT-1:0] claim_vec;
   logic [SLOT_COUNT-1:0] drive_vec;
   logic [SLOT_COUNT-1:0] level_vec;
   logic [SLOT_W-1:0]     hit_slot;
   logic                  miss;
   logic [MASK_W-1:0]     type_mask;
   logic [MASK_W-1:0]     level_mask;
   logic                  out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;

   // split the decimal number into group and pin
   always_comb begin
      quot_prod = PROD_W'(req_ch.gpio_number) * PROD_W'(DIV10_MUL);
      group     = quot_prod[PROD_W-1:DIV10_SHIFT];
      tens      = NUMBER_W'(group) * NUMBER_W'(DIGIT_BASE);
      pin       = req_ch.gpio_number - tens;
      bad_pin   = (pin > NUMBER_W'(PIN_MAX)) || (group > GROUP_W'(GROUP_MAX));
      req_in.code      = {group[3:0], pin[3:0]};
      req_in.level     = req_ch.level;
      req_in.push_pull = req_ch.push_pull;
   end

   assign start    = accept & ~bad_pin;
   assign probe[0] = start;
   assign miss     = probe[SLOT_COUNT];

   // chain of slot cells
   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      gosm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (probe[g]),
         .req       (req_ff),
         .probe_out (probe[g+1]),
         .stat      (stat[g]),
         .drive_bit (drive_vec[g]),
         .level_bit (level_vec[g])
      );
      assign hit_vec[g]   = stat[g].hit;
      assign claim_vec[g] = stat[g].claim;
   end

   // slot index of the hit and the masks padded to full width
   always_comb begin
      hit_slot   = '0;
      type_mask  = '0;
      level_mask = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (hit_vec[i]) begin
            hit_slot = hit_slot | SLOT_W'(i);
         end
         type_mask[i]  = drive_vec[i];
         level_mask[i] = level_vec[i];
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_level_in  = rsp_level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (bad_pin) begin
                  status_in = STATUS_INVALID;
                  slot_in   = '0;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (|hit_vec) begin
               status_in = (|claim_vec) ? STATUS_NEW : STATUS_REUSED;
               slot_in   = hit_slot;
               state_in  = ST_EMIT;
            end else if (miss) begin
               status_in = STATUS_FULL;
               slot_in   = '0;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff;
               rsp_type_in   = type_mask;
               rsp_level_in  = level_mask;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.slot       = rsp_slot_ff;
   assign rsp_ch.type_mask  = rsp_type_ff;
   assign rsp_ch.level_mask = rsp_level_ff;

   // at most one cell stops the probe
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one slot hit");

   // no probe activity outside a scan
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> (hit_vec == '0) && !miss)
      else $error("probe active outside a scan");

   // a valid pin starts a scan
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_SCAN))
      else $error("scan not started after request");

endmodule

`default_nettype wire

// ===== bench/gpio_output_slot_mapper_core_test.sv =====
// gpio_output_slot_mapper_core_test: self-checking bench for the output slot mapper
// depends on gosm_pkg, gosm_req_if, gosm_rsp_if and the gpio_output_slot_mapper_core rtl
// a scoreboard class tracks the slot table and both masks and checks every result in order
`timescale 1ns / 1ps

module gpio_output_slot_mapper_core_test;
   import gosm_pkg::*;

   localparam int SLOT_COUNT  = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_REQS = 1000;

   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [MASK_W-1:0] type_mask;
      logic [MASK_W-1:0] level_mask;
   } mapping_result_t;

   // mirror of the slot table and masks, plus the queue of results still owed
   class slot_map_scoreboard;
      logic [CODE_W-1:0] slot_codes [SLOT_COUNT];
      logic [MASK_W-1:0] drive_mask;
      logic [MASK_W-1:0] level_bits;
      mapping_result_t   owed_results [$];
      int                errors;
      int                status_count [4];

      function new();
         foreach (slot_codes[i]) slot_codes[i] = UNUSED_CODE;
         foreach (status_count[i]) status_count[i] = 0;
         drive_mask = '0;
         level_bits = '0;
         errors     = 0;
      endfunction

      // apply one accepted request to the mirror and queue its result
      function void note_request(logic [NUMBER_W-1:0] number, logic lvl, logic pp);
         int              group;
         int              pin;
         int              hit;
         logic [CODE_W-1:0] code;
         mapping_result_t res;
         group    = number / DIGIT_BASE;
         pin      = number % DIGIT_BASE;
         res.slot = '0;
         if (pin > PIN_MAX || group > GROUP_MAX) begin
            res.status = STATUS_INVALID;
         end else begin
            code = CODE_W'((group << 4) | pin);
            hit  = -1;
            // first slot that is free or already holds this pin wins
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (hit < 0 && (slot_codes[i] == UNUSED_CODE || slot_codes[i] == code))
                  hit = i;
            end
            if (hit < 0) begin
               res.status = STATUS_FULL;
            end else begin
               if (slot_codes[hit] == UNUSED_CODE) begin
                  slot_codes[hit] = code;
                  res.status      = STATUS_NEW;
               end else begin
                  res.status = STATUS_REUSED;
               end
               drive_mask[hit] = pp;
               level_bits[hit] = lvl;
               res.slot        = SLOT_W'(hit);
            end
         end
         res.type_mask  = drive_mask;
         res.level_mask = level_bits;
         status_count[res.status]++;
         owed_results.push_back(res);
      endfunction

      // compare one delivered result against the oldest owed one
      function void check_result(status_type st, logic [SLOT_W-1:0] slot,
                                 logic [MASK_W-1:0] tm, logic [MASK_W-1:0] lm);
         mapping_result_t want;
         if (owed_results.size() == 0) begin
            $error("unexpected result: status %0d slot %0d", st, slot);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            errors++;
         end
         if (slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot);
            errors++;
         end
         if (tm !== want.type_mask) begin
            $error("type_mask: expected %h, actual %h", want.type_mask, tm);
            errors++;
         end
         if (lm !== want.level_mask) begin
            $error("level_mask: expected %h, actual %h", want.level_mask, lm);
            errors++;
         end
      endfunction

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   send_idle_pct;
   int   recv_idle_pct;

   // pin numbers that end up in the table, in slot order
   logic [NUMBER_W-1:0] mapped_ids [SLOT_COUNT] =
      '{8'd0, 8'd97, 8'd7, 8'd10, 8'd17, 8'd20, 8'd33, 8'd45,
        8'd56, 8'd61, 8'd72, 8'd84, 8'd90, 8'd91, 8'd37, 8'd77};

   slot_map_scoreboard pin_map;

   gosm_req_if req ();
   gosm_rsp_if rsp ();

   gpio_output_slot_mapper_core #(
      .SLOT_COUNT (SLOT_COUNT)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pin_map.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: check on handshake, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready)
            pin_map.check_result(rsp.status, rsp.slot, rsp.type_mask, rsp.level_mask);
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // drive one request, with random idle cycles ahead of it
   task automatic send_request(input logic [NUMBER_W-1:0] number,
                               input logic lvl, input logic pp);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.gpio_number <= number;
      req.level       <= lvl;
      req.push_pull   <= pp;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pin_map.note_request(number, lvl, pp);
   endtask

   task automatic wait_for_results();
      while (pin_map.pending() != 0) @(posedge clock);
   endtask

   // one random request: mostly pins already mapped, some fresh pins, some noise
   task automatic send_random_request();
      int                  pick;
      logic [NUMBER_W-1:0] number;
      pick = $urandom_range(99);
      if (pick < 70)
         number = mapped_ids[$urandom_range(SLOT_COUNT - 1)];
      else if (pick < 85)
         number = NUMBER_W'($urandom_range(GROUP_MAX) * DIGIT_BASE + $urandom_range(PIN_MAX));
      else
         number = NUMBER_W'($urandom_range(255));
      send_request(number, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   initial begin
      pin_map = new();
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.gpio_number <= '0;
      req.level       <= 1'b0;
      req.push_pull   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: rejected numbers (bad pin digit, group above nine, extremes)
      send_request(8'd8,   1'b1, 1'b1);
      send_request(8'd9,   1'b0, 1'b1);
      send_request(8'd98,  1'b1, 1'b0);
      send_request(8'd99,  1'b1, 1'b1);
      send_request(8'd100, 1'b0, 1'b0);
      send_request(8'd255, 1'b1, 1'b1);
      // lowest and highest valid pins, each allocated and then reused
      send_request(mapped_ids[0], 1'b1, 1'b1);
      send_request(mapped_ids[0], 1'b0, 1'b0);
      send_request(mapped_ids[1], 1'b1, 1'b0);
      send_request(mapped_ids[1], 1'b0, 1'b1);
      // fill the rest of the table, then one more pin finds it full
      for (int i = 2; i < SLOT_COUNT; i++)
         send_request(mapped_ids[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
      send_request(8'd50, 1'b1, 1'b1);

      // random: sender idles lightly, receiver stalls hard
      send_idle_pct = 10;
      recv_idle_pct = 55;
      for (int n = 0; n < RANDOM_REQS / 3; n++) send_random_request();

      // hold off until the block has drained
      req.valid <= 1'b0;
      wait_for_results();

      // random: sender idles hard, receiver stalls lightly
      send_idle_pct = 55;
      recv_idle_pct = 10;
      for (int n = 0; n < RANDOM_REQS / 3; n++) send_random_request();

      // random: back to back on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < RANDOM_REQS - 2 * (RANDOM_REQS / 3); n++) send_random_request();

      req.valid <= 1'b0;
      wait_for_results();
      repeat (SLOT_COUNT + 8) @(posedge clock);

      $display("covered %0d new slots, %0d reuses, %0d rejected pins, %0d full-table misses",
               pin_map.status_count[STATUS_NEW], pin_map.status_count[STATUS_REUSED],
               pin_map.status_count[STATUS_INVALID], pin_map.status_count[STATUS_FULL]);
      $display("under sender gaps and receiver stalls in both mixes; %0d mismatches",
               pin_map.errors);
      if (pin_map.errors == 0 && pin_map.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
